// ===== rtl/mrfc_pkg.sv =====
`timescale 1ns / 1ps
package mrfc_pkg;

   localparam int MAX_VALUES  = 4;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0]  BYTE_MASK = 8'hFF;
   localparam logic [15:0] CRC_INIT  = 16'hFFFF;
   localparam logic [15:0] CRC_POLY  = 16'hA001;

   localparam logic [1:0] REG_DEVICE_ADDRESS  = 2'd0;
   localparam logic [1:0] REG_EXPECTED_LENGTH = 2'd1;
   localparam logic [1:0] REG_VALUE_COUNT     = 2'd2;

   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_BAD_LENGTH  = 2'd1;
   localparam logic [1:0] ST_BAD_CRC     = 2'd2;
   localparam logic [1:0] ST_BAD_ADDRESS = 2'd3;

   localparam logic KIND_VALUE  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef enum logic [1:0] {
      OP_ADDR,
      OP_GROUP_BYTE,
      OP_GROUP_END,
      OP_TAIL
   } op_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_last;
      op_type     op;
      logic       len_ok;
      logic [1:0] value_index;
   } entry_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) c = (c >> 1) ^ CRC_POLY;
         else      c = c >> 1;
      end
      return c;
   endfunction

endpackage

// ===== rtl/mrfc_front.sv =====
`timescale 1ns / 1ps
module mrfc_front
   import mrfc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [7:0] req_rx_byte,
   input  logic       req_frame_last,
   input  logic [7:0] expected_length,
   input  logic [2:0] value_count,
   input  logic       q_full,
   output logic       q_push,
   output entry_type  q_entry
);

   logic [7:0] byte_count_ff, byte_count_in;
   logic [2:0] group_index_ff, group_index_in;
   logic [2:0] limit;
   logic [7:0] count_next;
   logic [7:0] pos_m1;
   op_type     op;

   assign q_push = req_valid && !q_full;

   always_comb begin
      limit      = (int'(value_count) < MAX_VALUES) ? value_count : 3'(MAX_VALUES);
      count_next = (byte_count_ff == BYTE_MASK) ? BYTE_MASK : byte_count_ff + 8'd1;
      pos_m1     = byte_count_ff - 8'd1;
      if (byte_count_ff == 8'd0) begin
         op = OP_ADDR;
      end else if (group_index_ff < limit) begin
         op = (pos_m1[1:0] == 2'b11) ? OP_GROUP_END : OP_GROUP_BYTE;
      end else begin
         op = OP_TAIL;
      end

      byte_count_in  = byte_count_ff;
      group_index_in = group_index_ff;
      if (q_push) begin
         if (req_frame_last) begin
            byte_count_in  = 8'd0;
            group_index_in = 3'd0;
         end else begin
            byte_count_in = count_next;
            if (op == OP_GROUP_END) group_index_in = group_index_ff + 3'd1;
         end
      end

      q_entry.rx_byte     = req_rx_byte;
      q_entry.frame_last  = req_frame_last;
      q_entry.op          = op;
      q_entry.len_ok      = (count_next == expected_length);
      q_entry.value_index = group_index_ff[1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff  <= 8'd0;
         group_index_ff <= 3'd0;
      end else begin
         byte_count_ff  <= byte_count_in;
         group_index_ff <= group_index_in;
      end
   end

endmodule

// ===== rtl/mrfc_queue.sv =====
`timescale 1ns / 1ps
module mrfc_queue
   import mrfc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type pop_entry,
   output logic      full,
   output logic      empty
);

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   entry_type            slots_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]      count_ff, count_in;

   assign full      = (count_ff == CntW'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign pop_entry = slots_ff[rd_ptr_ff];

   function automatic logic [PtrW-1:0] ptr_step(input logic [PtrW-1:0] p);
      return (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + PtrW'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_step(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_step(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + CntW'(1);
      if (pop && !push) count_in = count_ff - CntW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slots_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

// ===== rtl/mrfc_back.sv =====
`timescale 1ns / 1ps
module mrfc_back
   import mrfc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   input  entry_type   q_entry,
   output logic        q_pop,
   input  logic [7:0]  device_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [31:0] rsp_energy_value,
   output logic [1:0]  rsp_value_index,
   output logic [1:0]  rsp_frame_status,
   output logic        rsp_frame_done
);

   logic [15:0] crc_ff, crc_in;
   logic [7:0]  first_byte_ff, first_byte_in;
   logic [23:0] group_buffer_ff, group_buffer_in;
   logic        valid_ff, valid_in;
   logic        kind_ff, kind_in;
   logic [31:0] value_ff, value_in;
   logic [1:0]  index_ff, index_in;
   logic [1:0]  status_ff, status_in;
   logic [15:0] crc_next;
   logic [7:0]  b;

   assign q_pop = !q_empty && (!valid_ff || !rsp_stall);
   assign b     = q_entry.rx_byte;

   always_comb begin
      crc_next        = crc16_byte(crc_ff, b);
      crc_in          = crc_ff;
      first_byte_in   = first_byte_ff;
      group_buffer_in = group_buffer_ff;
      valid_in        = valid_ff && rsp_stall;
      kind_in         = kind_ff;
      value_in        = value_ff;
      index_in        = index_ff;
      status_in       = status_ff;

      if (q_pop) begin
         crc_in = crc_next;
         case (q_entry.op)
            OP_ADDR:       first_byte_in   = b;
            OP_GROUP_BYTE: group_buffer_in = {group_buffer_ff[15:0], b};
            OP_GROUP_END:  group_buffer_in = 24'd0;
            default:       ;
         endcase

         if (q_entry.frame_last) begin
            valid_in  = 1'b1;
            kind_in   = KIND_STATUS;
            value_in  = 32'd0;
            index_in  = 2'd0;
            if (!q_entry.len_ok)                  status_in = ST_BAD_LENGTH;
            else if (crc_next != 16'd0)           status_in = ST_BAD_CRC;
            else if (first_byte_in != device_address) status_in = ST_BAD_ADDRESS;
            else                                  status_in = ST_OK;
            crc_in          = CRC_INIT;
            first_byte_in   = 8'd0;
            group_buffer_in = 24'd0;
         end else if (q_entry.op == OP_GROUP_END) begin
            valid_in  = 1'b1;
            kind_in   = KIND_VALUE;
            // wire order is bytes 2,1,4,3 of the group
            value_in  = {group_buffer_ff[15:8], group_buffer_ff[23:16], b,
                         group_buffer_ff[7:0]};
            index_in  = q_entry.value_index;
            status_in = ST_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff          <= CRC_INIT;
         first_byte_ff   <= 8'd0;
         group_buffer_ff <= 24'd0;
         valid_ff        <= 1'b0;
      end else begin
         crc_ff          <= crc_in;
         first_byte_ff   <= first_byte_in;
         group_buffer_ff <= group_buffer_in;
         valid_ff        <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      value_ff  <= value_in;
      index_ff  <= index_in;
      status_ff <= status_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_result_kind  = kind_ff;
   assign rsp_energy_value = value_ff;
   assign rsp_value_index  = index_ff;
   assign rsp_frame_status = status_ff;
   assign rsp_frame_done   = kind_ff;

endmodule

// ===== rtl/meter_response_frame_checker.sv =====
`timescale 1ns / 1ps
// response frame checker for a metering serial link
// req channel: one received byte per beat, req_frame_last set on the final byte
// rsp channel: an energy value beat for every complete 4-byte group among the
//   first value_count groups (at most 4) after the address byte, and one status
//   beat per frame (ok, bad length, bad crc, wrong address, tested in that order)
// throughput: one byte per cycle while req_stall is low; the front stage counts and
//   classifies the byte, a 4-entry queue decouples it from the back stage that
//   runs the byte-wide crc-16 update and assembles values into the output register
// path: a taken byte is written into a queue slot, then popped by the back stage,
//   which places its result in the output register
// while rsp_stall is high with a result pending the output register holds; the
//   queue keeps taking bytes until it is full, then req_stall goes high
// reset: frame state cleared, crc at 0xffff, registers at address 0,
//   length 19, value count 4; no clearing pass is needed
// csr: apb write at 0x0 device address, 0x4 expected length, 0x8 value count;
//   write only while no frame is in flight
module meter_response_frame_checker
   import mrfc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_frame_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [31:0] rsp_energy_value,
   output logic [1:0]  rsp_value_index,
   output logic [1:0]  rsp_frame_status,
   output logic        rsp_frame_done,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [7:0] device_address_ff, device_address_in;
   logic [7:0] expected_length_ff, expected_length_in;
   logic [2:0] value_count_ff, value_count_in;
   logic       csr_write;
   logic       q_push, q_pop, q_full, q_empty;
   entry_type  push_entry, pop_entry;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      device_address_in  = device_address_ff;
      expected_length_in = expected_length_ff;
      value_count_in     = value_count_ff;
      if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_DEVICE_ADDRESS:  device_address_in  = csr_pwdata[7:0];
            REG_EXPECTED_LENGTH: expected_length_in = csr_pwdata[7:0];
            REG_VALUE_COUNT:     value_count_in     = csr_pwdata[2:0];
            default:             ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_DEVICE_ADDRESS:  csr_prdata = {24'd0, device_address_ff};
         REG_EXPECTED_LENGTH: csr_prdata = {24'd0, expected_length_ff};
         REG_VALUE_COUNT:     csr_prdata = {29'd0, value_count_ff};
         default:             csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff  <= 8'd0;
         expected_length_ff <= 8'd19;
         value_count_ff     <= 3'd4;
      end else begin
         device_address_ff  <= device_address_in;
         expected_length_ff <= expected_length_in;
         value_count_ff     <= value_count_in;
      end
   end

   assign req_stall = q_full;

   mrfc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_rx_byte     (req_rx_byte),
      .req_frame_last  (req_frame_last),
      .expected_length (expected_length_ff),
      .value_count     (value_count_ff),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_entry         (push_entry)
   );

   mrfc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .pop_entry  (pop_entry),
      .full       (q_full),
      .empty      (q_empty)
   );

   mrfc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_entry          (pop_entry),
      .q_pop            (q_pop),
      .device_address   (device_address_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_energy_value (rsp_energy_value),
      .rsp_value_index  (rsp_value_index),
      .rsp_frame_status (rsp_frame_status),
      .rsp_frame_done   (rsp_frame_done)
   );

   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("queue written while full");

   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_empty)
      else $error("queue read while empty");

   assert property (@(posedge clock) reset |=> !rsp_valid && q_empty)
      else $error("output or queue not clear after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_VALUE |-> rsp_frame_status == ST_OK)
      else $error("value beat carries a status code");

endmodule
